// ===== rtl/core/mecanum_ramp_and_wheel_mix_macros.svh =====
// Assertion macros shared by the mecanum wheel mixer RTL.
// Included by the top level; no other dependencies.
`ifndef MECANUM_RAMP_AND_WHEEL_MIX_MACROS_SVH
`define MECANUM_RAMP_AND_WHEEL_MIX_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define MRWM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define MRWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define MRWM_ASSERT_SAME(label, clk, rst, ante, cons)
`define MRWM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/mrwm_pkg.sv =====
// Shared types and constants for the mecanum ramp and wheel mixer.
// No dependencies; used by the sequencer, microcode ROM, divider lane and top level.
package mrwm_pkg;

   localparam int SPEED_W    = 15;  // signed speed commands and wheel targets
   localparam int CFG_W      = 14;  // unsigned configuration values
   localparam int WHEEL_W    = 17;  // full-width signed wheel sums
   localparam int MAG_W      = 16;  // magnitude of a wheel sum
   localparam int DIVIDEND_W = MAG_W + CFG_W;
   localparam int QUOT_W     = CFG_W;
   localparam int NUM_WHEELS = 4;
   localparam int CSR_IDX_W  = 3;

   localparam int PC_W       = 4;
   localparam int CNT_W      = 4;
   localparam logic [CNT_W-1:0] DIV_LAST_CNT = CNT_W'(QUOT_W - 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAUNCH_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_STEP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LAUNCH_THR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_LIMIT = 3'd5;

   localparam logic [CFG_W-1:0] WHEEL_LIMIT_RESET = 14'd8000;

   // Wheel order in the result.
   localparam int WHEEL_LF = 0;
   localparam int WHEEL_RF = 1;
   localparam int WHEEL_RB = 2;
   localparam int WHEEL_LB = 3;

   // Program addresses.
   localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
   localparam logic [PC_W-1:0] PC_CLAMP = 4'd1;
   localparam logic [PC_W-1:0] PC_RAMP  = 4'd2;
   localparam logic [PC_W-1:0] PC_MIX   = 4'd3;
   localparam logic [PC_W-1:0] PC_PEAK  = 4'd4;
   localparam logic [PC_W-1:0] PC_MUL   = 4'd5;
   localparam logic [PC_W-1:0] PC_DIV   = 4'd6;
   localparam logic [PC_W-1:0] PC_FIX   = 4'd7;
   localparam logic [PC_W-1:0] PC_EMIT  = 4'd8;

   typedef enum logic [3:0] {
      OP_NOP   = 4'd0,
      OP_CLAMP = 4'd1,
      OP_RAMP  = 4'd2,
      OP_MIX   = 4'd3,
      OP_PEAK  = 4'd4,
      OP_MUL   = 4'd5,
      OP_DIV   = 4'd6,
      OP_FIX   = 4'd7,
      OP_EMIT  = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      JMP_NEXT      = 2'd0,
      JMP_ALWAYS    = 2'd1,
      JMP_SCALE_OFF = 2'd2,
      JMP_DIV_BUSY  = 2'd3
   } jump_type;

   typedef struct packed {
      op_type           op;
      jump_type         jump;
      logic [PC_W-1:0]  target;
   } ucode_word_type;

   typedef struct packed {
      op_type op;
      logic   fire;   // the current control word executes this cycle
      logic   busy;   // a transaction is in flight
   } seq_ctrl_type;

   typedef struct packed {
      logic req_valid;   // an input transaction is offered
      logic out_blocked;
      logic scale_off;
   } seq_status_type;

endpackage

// ===== rtl/core/mrwm_ucode_rom.sv =====
// Microcode ROM: one control word per program step.
// Depends on mrwm_pkg.
module mrwm_ucode_rom (
   input  logic [mrwm_pkg::PC_W-1:0] pc,
   output mrwm_pkg::ucode_word_type  word
);
   import mrwm_pkg::*;

   always_comb begin
      unique case (pc)
         PC_IDLE:  word = '{op: OP_NOP,   jump: JMP_NEXT,      target: PC_IDLE};
         PC_CLAMP: word = '{op: OP_CLAMP, jump: JMP_NEXT,      target: PC_IDLE};
         PC_RAMP:  word = '{op: OP_RAMP,  jump: JMP_NEXT,      target: PC_IDLE};
         PC_MIX:   word = '{op: OP_MIX,   jump: JMP_NEXT,      target: PC_IDLE};
         PC_PEAK:  word = '{op: OP_PEAK,  jump: JMP_SCALE_OFF, target: PC_EMIT};
         PC_MUL:   word = '{op: OP_MUL,   jump: JMP_NEXT,      target: PC_IDLE};
         PC_DIV:   word = '{op: OP_DIV,   jump: JMP_DIV_BUSY,  target: PC_DIV};
         PC_FIX:   word = '{op: OP_FIX,   jump: JMP_NEXT,      target: PC_IDLE};
         PC_EMIT:  word = '{op: OP_EMIT,  jump: JMP_ALWAYS,    target: PC_IDLE};
         default:  word = '{op: OP_NOP,   jump: JMP_ALWAYS,    target: PC_IDLE};
      endcase
   end

endmodule

// ===== rtl/core/mrwm_sequencer.sv =====
// Step counter, jump logic and division loop counter around the microcode ROM.
// Depends on mrwm_pkg and mrwm_ucode_rom.
module mrwm_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  mrwm_pkg::seq_status_type status,
   output mrwm_pkg::seq_ctrl_type   ctrl
);
   import mrwm_pkg::*;

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   ucode_word_type   word;
   logic             hold;
   logic             taken;

   mrwm_ucode_rom u_rom (
      .pc   (pc_ff),
      .word (word)
   );

   // The idle step waits for a transaction; stall is low there, so an offered one is taken.
   // The emit step waits for the output register.
   assign hold = ((pc_ff == PC_IDLE) && !status.req_valid) ||
                 ((word.op == OP_EMIT) && status.out_blocked);

   always_comb begin
      unique case (word.jump)
         JMP_NEXT:      taken = 1'b0;
         JMP_ALWAYS:    taken = 1'b1;
         JMP_SCALE_OFF: taken = status.scale_off;
         JMP_DIV_BUSY:  taken = (div_cnt_ff != '0);
         default:       taken = 1'b0;
      endcase
   end

   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = PC_W'(pc_ff + 1'b1);
      end
   end

   always_comb begin
      div_cnt_in = div_cnt_ff;
      if (word.op == OP_MUL) begin
         div_cnt_in = DIV_LAST_CNT;
      end else if ((word.op == OP_DIV) && (div_cnt_ff != '0)) begin
         div_cnt_in = CNT_W'(div_cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= PC_IDLE;
         div_cnt_ff <= '0;
      end else begin
         pc_ff      <= pc_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.fire = !hold;
   assign ctrl.busy = (pc_ff != PC_IDLE);

endmodule

// ===== rtl/core/mrwm_div_lane.sv =====
// Restoring divider lane: one quotient bit per step, quotient known to fit QUOT_W bits.
// Depends on mrwm_pkg.
module mrwm_div_lane (
   input  logic                             clock,
   input  logic                             load,
   input  logic                             step,
   input  logic [mrwm_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [mrwm_pkg::MAG_W-1:0]       divisor,
   output logic [mrwm_pkg::QUOT_W-1:0]      quotient
);
   import mrwm_pkg::*;

   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] low_ff, low_in;
   logic [MAG_W:0]    shifted;
   logic              fits;

   // The quotient is below 2**QUOT_W, so the upper dividend bits start below the divisor.
   assign shifted = {rem_ff, low_ff[QUOT_W-1]};
   assign fits    = (shifted >= {1'b0, divisor});

   always_comb begin
      rem_in = rem_ff;
      low_in = low_ff;
      if (load) begin
         rem_in = dividend[DIVIDEND_W-1:QUOT_W];
         low_in = dividend[QUOT_W-1:0];
      end else if (step) begin
         if (fits) begin
            rem_in = MAG_W'(shifted - {1'b0, divisor});
         end else begin
            rem_in = shifted[MAG_W-1:0];
         end
         low_in = {low_ff[QUOT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign quotient = low_ff;

endmodule

// ===== rtl/core/mecanum_ramp_and_wheel_mix.sv =====
// With wheel scaling the program steps through clamp, ramp, mix, peak, multiply, divide
// (in the four parallel divider lanes), fix and emit; without it, peak jumps to emit.
// A new transaction is taken only once the microcode program returns to its idle step;
// the emit step waits while the output register holds a stalled result.
// Reset clears the program counter, output valid, ramp state and configuration
// (ramp off, steps and launch threshold zero, wheel speed limit 8000).
// Top level: datapath, configuration registers, output register.
// Depends on mrwm_pkg, mrwm_sequencer, mrwm_div_lane and the macros header.
`include "mecanum_ramp_and_wheel_mix_macros.svh"

module mecanum_ramp_and_wheel_mix (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [mrwm_pkg::SPEED_W-1:0]   req_cmd_x,
   input  logic signed [mrwm_pkg::SPEED_W-1:0]   req_cmd_y,
   input  logic signed [mrwm_pkg::SPEED_W-1:0]   req_cmd_z,
   input  logic                                  req_halt,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mrwm_pkg::SPEED_W-1:0]   rsp_wheel_lf,
   output logic signed [mrwm_pkg::SPEED_W-1:0]   rsp_wheel_rf,
   output logic signed [mrwm_pkg::SPEED_W-1:0]   rsp_wheel_rb,
   output logic signed [mrwm_pkg::SPEED_W-1:0]   rsp_wheel_lb,
   output logic                                  rsp_scaled_down,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mrwm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mrwm_pkg::CFG_W-1:0]            csr_wdata
);
   import mrwm_pkg::*;

   function automatic logic signed [SPEED_W-1:0] clamp_lim(
      input logic signed [SPEED_W-1:0] v,
      input logic [CFG_W-1:0]          lim
   );
      logic signed [SPEED_W:0] pos;
      logic signed [SPEED_W:0] neg;
      pos = $signed({2'b00, lim});
      neg = -pos;
      if ($signed({v[SPEED_W-1], v}) > pos) begin
         return pos[SPEED_W-1:0];
      end else if ($signed({v[SPEED_W-1], v}) < neg) begin
         return neg[SPEED_W-1:0];
      end
      return v;
   endfunction

   function automatic logic [SPEED_W-1:0] mag15(input logic signed [SPEED_W-1:0] v);
      logic signed [SPEED_W-1:0] n;
      n = -v;
      return v[SPEED_W-1] ? n : v;
   endfunction

   function automatic logic signed [SPEED_W-1:0] ramp_axis(
      input logic signed [SPEED_W-1:0] cmd,
      input logic signed [SPEED_W-1:0] last,
      input logic [CFG_W-1:0]          ls,
      input logic [CFG_W-1:0]          ns,
      input logic [CFG_W-1:0]          bs,
      input logic [CFG_W-1:0]          thr
   );
      logic [SPEED_W-1:0]       mc;
      logic [SPEED_W-1:0]       ml;
      logic signed [SPEED_W:0]  diff;
      logic signed [SPEED_W:0]  ndiff;
      logic [SPEED_W:0]         md;
      logic [CFG_W-1:0]         st;
      logic signed [SPEED_W:0]  nxt;
      mc    = mag15(cmd);
      ml    = mag15(last);
      diff  = $signed({cmd[SPEED_W-1], cmd}) - $signed({last[SPEED_W-1], last});
      ndiff = -diff;
      md    = diff[SPEED_W] ? ndiff : diff;
      if (mc > ml) begin
         st = (mc <= {1'b0, thr}) ? ls : ns;
      end else begin
         st = bs;
      end
      if (md >= {2'b00, st}) begin
         if (cmd >= last) begin
            nxt = $signed({last[SPEED_W-1], last}) + $signed({2'b00, st});
         end else begin
            nxt = $signed({last[SPEED_W-1], last}) - $signed({2'b00, st});
         end
         return nxt[SPEED_W-1:0];
      end
      return cmd;
   endfunction

   function automatic logic [MAG_W-1:0] mag17(input logic signed [WHEEL_W-1:0] v);
      logic signed [WHEEL_W-1:0] n;
      n = -v;
      return v[WHEEL_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   seq_ctrl_type   ctrl;
   seq_status_type status;

   logic req_fire;
   logic rsp_fire;
   logic out_blocked;

   // Configuration registers.
   logic              ramp_en_ff;
   logic [CFG_W-1:0]  launch_step_ff;
   logic [CFG_W-1:0]  normal_step_ff;
   logic [CFG_W-1:0]  brake_step_ff;
   logic [CFG_W-1:0]  launch_thr_ff;
   logic [CFG_W-1:0]  limit_ff;

   // Datapath registers.
   logic signed [SPEED_W-1:0] x_ff, y_ff, z_ff;
   logic signed [SPEED_W-1:0] x_in, y_in, z_in;
   logic                      halt_ff;
   logic signed [SPEED_W-1:0] ramp_x_ff, ramp_y_ff;
   logic signed [SPEED_W-1:0] ramp_x_in, ramp_y_in;
   logic signed [SPEED_W-1:0] next_rx, next_ry;
   logic signed [WHEEL_W-1:0] w_ff [NUM_WHEELS];
   logic signed [WHEEL_W-1:0] w_in [NUM_WHEELS];
   logic signed [WHEEL_W-1:0] vx17, vy17, vz17;
   logic [MAG_W-1:0]          wmag [NUM_WHEELS];
   logic [MAG_W-1:0]          peak01, peak23, peak;
   logic [MAG_W-1:0]          peak_ff, peak_in;
   logic                      scale_hit;
   logic                      scale_ff, scale_in;
   logic [DIVIDEND_W-1:0]     prod [NUM_WHEELS];
   logic [QUOT_W-1:0]         quot [NUM_WHEELS];
   logic                      lane_load, lane_step;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_w_ff [NUM_WHEELS];
   logic                      rsp_scaled_ff;
   logic                      emit;

   assign req_fire    = req_valid && !req_stall;
   assign rsp_fire    = rsp_valid_ff && !rsp_stall;
   assign out_blocked = rsp_valid_ff && rsp_stall;

   assign status.req_valid   = req_valid;
   assign status.out_blocked = out_blocked;
   assign status.scale_off   = !scale_hit;

   mrwm_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_stall = ctrl.busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_en_ff     <= 1'b0;
         launch_step_ff <= '0;
         normal_step_ff <= '0;
         brake_step_ff  <= '0;
         launch_thr_ff  <= '0;
         limit_ff       <= WHEEL_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RAMP_ENABLE: ramp_en_ff     <= csr_wdata[0];
            CSR_LAUNCH_STEP: launch_step_ff <= csr_wdata;
            CSR_NORMAL_STEP: normal_step_ff <= csr_wdata;
            CSR_BRAKE_STEP:  brake_step_ff  <= csr_wdata;
            CSR_LAUNCH_THR:  launch_thr_ff  <= csr_wdata;
            CSR_WHEEL_LIMIT: limit_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign next_rx = ramp_axis(x_ff, ramp_x_ff, launch_step_ff, normal_step_ff,
                              brake_step_ff, launch_thr_ff);
   assign next_ry = ramp_axis(y_ff, ramp_y_ff, launch_step_ff, normal_step_ff,
                              brake_step_ff, launch_thr_ff);

   assign vx17 = WHEEL_W'(x_ff);
   assign vy17 = WHEEL_W'(y_ff);
   assign vz17 = WHEEL_W'(z_ff);

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         wmag[i] = mag17(w_ff[i]);
         prod[i] = DIVIDEND_W'(wmag[i]) * DIVIDEND_W'(limit_ff);
      end
   end

   assign peak01 = (wmag[WHEEL_LF] > wmag[WHEEL_RF]) ? wmag[WHEEL_LF] : wmag[WHEEL_RF];
   assign peak23 = (wmag[WHEEL_RB] > wmag[WHEEL_LB]) ? wmag[WHEEL_RB] : wmag[WHEEL_LB];
   assign peak   = (peak01 > peak23) ? peak01 : peak23;

   // Scaling is never applied when every wheel is zero.
   assign scale_hit = (peak != '0) && (peak >= {2'b00, limit_ff});

   // Velocity registers hold the command, then its clamped value, then the velocity.
   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      ramp_x_in = ramp_x_ff;
      ramp_y_in = ramp_y_ff;
      peak_in   = peak_ff;
      scale_in  = scale_ff;
      emit      = 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         w_in[i] = w_ff[i];
      end
      if (req_fire) begin
         x_in = req_cmd_x;
         y_in = req_cmd_y;
         z_in = req_cmd_z;
      end else if (ctrl.fire) begin
         unique case (ctrl.op)
            OP_CLAMP: begin
               x_in = clamp_lim(x_ff, limit_ff);
               y_in = clamp_lim(y_ff, limit_ff);
               z_in = clamp_lim(z_ff, limit_ff);
            end
            OP_RAMP: begin
               if (halt_ff) begin
                  x_in = '0;
                  y_in = '0;
                  z_in = '0;
               end else if (ramp_en_ff) begin
                  x_in      = next_rx;
                  y_in      = next_ry;
                  ramp_x_in = next_rx;
                  ramp_y_in = next_ry;
               end
            end
            OP_MIX: begin
               w_in[WHEEL_LF] = vx17 + vy17 + vz17;
               w_in[WHEEL_RF] = vx17 - vy17 + vz17;
               w_in[WHEEL_RB] = -vx17 - vy17 + vz17;
               w_in[WHEEL_LB] = -vx17 + vy17 + vz17;
            end
            OP_PEAK: begin
               peak_in  = peak;
               scale_in = scale_hit;
            end
            OP_FIX: begin
               for (int i = 0; i < NUM_WHEELS; i++) begin
                  w_in[i] = w_ff[i][WHEEL_W-1] ? -WHEEL_W'(quot[i]) : WHEEL_W'(quot[i]);
               end
            end
            OP_EMIT: emit = 1'b1;
            OP_NOP, OP_MUL, OP_DIV: ;
            default: ;
         endcase
      end
   end

   assign lane_load = ctrl.fire && (ctrl.op == OP_MUL);
   assign lane_step = ctrl.fire && (ctrl.op == OP_DIV);

   for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
      mrwm_div_lane u_div (
         .clock    (clock),
         .load     (lane_load),
         .step     (lane_step),
         .dividend (prod[g]),
         .divisor  (peak_ff),
         .quotient (quot[g])
      );
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      peak_ff <= peak_in;
      if (req_fire) begin
         halt_ff <= req_halt;
      end
      for (int i = 0; i < NUM_WHEELS; i++) begin
         w_ff[i] <= w_in[i];
      end
      if (emit) begin
         for (int i = 0; i < NUM_WHEELS; i++) begin
            rsp_w_ff[i] <= w_ff[i][SPEED_W-1:0];
         end
         rsp_scaled_ff <= scale_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_x_ff    <= '0;
         ramp_y_ff    <= '0;
         scale_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ramp_x_ff    <= ramp_x_in;
         ramp_y_ff    <= ramp_y_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wheel_lf    = rsp_w_ff[WHEEL_LF];
   assign rsp_wheel_rf    = rsp_w_ff[WHEEL_RF];
   assign rsp_wheel_rb    = rsp_w_ff[WHEEL_RB];
   assign rsp_wheel_lb    = rsp_w_ff[WHEEL_LB];
   assign rsp_scaled_down = rsp_scaled_ff;

   // An accepted transaction keeps the program busy in the following cycle.
   `MRWM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, req_stall)
   // The divider lanes only run when scaling was chosen at the peak step.
   `MRWM_ASSERT_SAME(a_div_needs_scale, clock, reset, lane_step, scale_ff)
   // With the ramp off, the ramp state does not move.
   `MRWM_ASSERT_NEXT(a_ramp_held, clock, reset, !ramp_en_ff,
                     $stable(ramp_x_ff) && $stable(ramp_y_ff))

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for mecanum_ramp_and_wheel_mix: directed and random control ticks under several
// handshake pacings, each result checked against a wheel target predictor kept in this file.
// Depends on mrwm_pkg and the RTL of the block.
module tb;
   import mrwm_pkg::*;

   localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
   localparam logic [CFG_W-1:0]          CFG_MAX   = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam int RANDOM_PER_PHASE = 320;
   localparam int SETTING_SPAN     = 80;
   localparam int SETTLE_CYCLES    = 32;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct {
      logic signed [SPEED_W-1:0] lf;
      logic signed [SPEED_W-1:0] rf;
      logic signed [SPEED_W-1:0] rb;
      logic signed [SPEED_W-1:0] lb;
      logic                      scaled;
   } wheel_targets_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [SPEED_W-1:0] req_cmd_x;
   logic signed [SPEED_W-1:0] req_cmd_y;
   logic signed [SPEED_W-1:0] req_cmd_z;
   logic req_halt;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SPEED_W-1:0] rsp_wheel_lf;
   logic signed [SPEED_W-1:0] rsp_wheel_rf;
   logic signed [SPEED_W-1:0] rsp_wheel_rb;
   logic signed [SPEED_W-1:0] rsp_wheel_lb;
   logic rsp_scaled_down;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   // Predictor copy of the configuration and of the slew limiter state.
   logic                      ramp_on       = 1'b0;
   logic [CFG_W-1:0]          launch_step_r = '0;
   logic [CFG_W-1:0]          normal_step_r = '0;
   logic [CFG_W-1:0]          brake_step_r  = '0;
   logic [CFG_W-1:0]          launch_thr_r  = '0;
   logic [CFG_W-1:0]          wheel_limit_r = WHEEL_LIMIT_RESET;
   logic signed [SPEED_W-1:0] slew_x = '0;
   logic signed [SPEED_W-1:0] slew_y = '0;

   wheel_targets_type pending_wheel_targets[$];
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int ticks_sent    = 0;
   int ticks_checked = 0;
   int halted_ticks  = 0;
   int scaled_seen   = 0;
   int settings_used = 0;
   int failures      = 0;
   int quiet_cycles  = 0;

   mecanum_ramp_and_wheel_mix DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd_x(req_cmd_x), .req_cmd_y(req_cmd_y), .req_cmd_z(req_cmd_z),
      .req_halt(req_halt),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_wheel_lf(rsp_wheel_lf), .rsp_wheel_rf(rsp_wheel_rf),
      .rsp_wheel_rb(rsp_wheel_rb), .rsp_wheel_lb(rsp_wheel_lb),
      .rsp_scaled_down(rsp_scaled_down),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int clamp_speed(input logic signed [SPEED_W-1:0] v, input int lim);
      int s;
      s = int'(v);
      if (s > lim) return lim;
      if (s < -lim) return -lim;
      return s;
   endfunction

   function automatic logic signed [SPEED_W-1:0] slew_toward(
      input int                        cmd,
      input logic signed [SPEED_W-1:0] last_v
   );
      int last;
      int diff;
      int step;
      last = int'(last_v);
      diff = cmd - last;
      if (magnitude(cmd) > magnitude(last)) begin
         step = (magnitude(cmd) <= int'(launch_thr_r)) ? int'(launch_step_r)
                                                       : int'(normal_step_r);
      end else begin
         step = int'(brake_step_r);
      end
      if (magnitude(diff) >= step) begin
         return SPEED_W'((cmd >= last) ? last + step : last - step);
      end
      return SPEED_W'(cmd);
   endfunction

   // Advances the slew state the way one accepted tick does and returns its wheel targets.
   function automatic wheel_targets_type predict_wheel_targets(
      input logic signed [SPEED_W-1:0] x_in,
      input logic signed [SPEED_W-1:0] y_in,
      input logic signed [SPEED_W-1:0] z_in,
      input logic                      halt_in
   );
      int lim;
      int cx;
      int cy;
      int cz;
      int vx;
      int vy;
      int vz;
      int largest;
      int i;
      int w[NUM_WHEELS];
      longint m;
      wheel_targets_type t;
      lim = int'(wheel_limit_r);
      cx = clamp_speed(x_in, lim);
      cy = clamp_speed(y_in, lim);
      cz = clamp_speed(z_in, lim);
      if (halt_in) begin
         vx = 0;
         vy = 0;
         vz = 0;
      end else begin
         if (ramp_on) begin
            slew_x = slew_toward(cx, slew_x);
            slew_y = slew_toward(cy, slew_y);
            vx = int'(slew_x);
            vy = int'(slew_y);
         end else begin
            vx = cx;
            vy = cy;
         end
         vz = cz;
      end
      w[WHEEL_LF] = vx + vy + vz;
      w[WHEEL_RF] = vx - vy + vz;
      w[WHEEL_RB] = -vx - vy + vz;
      w[WHEEL_LB] = -vx + vy + vz;
      largest = 0;
      for (i = 0; i < NUM_WHEELS; i++) begin
         if (magnitude(w[i]) > largest) largest = magnitude(w[i]);
      end
      t.scaled = (largest > 0) && (largest >= lim);
      if (t.scaled) begin
         for (i = 0; i < NUM_WHEELS; i++) begin
            m = longint'(magnitude(w[i])) * lim / largest;
            w[i] = (w[i] < 0) ? -int'(m) : int'(m);
         end
      end
      t.lf = SPEED_W'(w[WHEEL_LF]);
      t.rf = SPEED_W'(w[WHEEL_RF]);
      t.rb = SPEED_W'(w[WHEEL_RB]);
      t.lb = SPEED_W'(w[WHEEL_LB]);
      return t;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
      case (idx)
         CSR_RAMP_ENABLE: ramp_on = data[0];
         CSR_LAUNCH_STEP: launch_step_r = data;
         CSR_NORMAL_STEP: normal_step_r = data;
         CSR_BRAKE_STEP:  brake_step_r = data;
         CSR_LAUNCH_THR:  launch_thr_r = data;
         CSR_WHEEL_LIMIT: wheel_limit_r = data;
         default: ;
      endcase
   endfunction

   // Follows every handshake: register writes and accepted ticks feed the predictor,
   // and each returned result is compared with the oldest prediction.
   always @(posedge clock) begin
      wheel_targets_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            pending_wheel_targets.push_back(
               predict_wheel_targets(req_cmd_x, req_cmd_y, req_cmd_z, req_halt));
            ticks_sent++;
            if (req_halt) halted_ticks++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_wheel_targets.size() == 0) begin
               failures++;
               if (failures <= SHOWN_MISMATCHES) begin
                  $display("%0t: result with no transaction outstanding:", $realtime);
                  $display("%0t:   lf=%0d rf=%0d rb=%0d lb=%0d", $realtime,
                           rsp_wheel_lf, rsp_wheel_rf, rsp_wheel_rb, rsp_wheel_lb);
               end
            end else begin
               want = pending_wheel_targets.pop_front();
               ticks_checked++;
               if (rsp_scaled_down === 1'b1) scaled_seen++;
               if (rsp_wheel_lf !== want.lf || rsp_wheel_rf !== want.rf ||
                   rsp_wheel_rb !== want.rb || rsp_wheel_lb !== want.lb ||
                   rsp_scaled_down !== want.scaled) begin
                  failures++;
                  if (failures <= SHOWN_MISMATCHES) begin
                     $display("%0t: expected lf=%0d rf=%0d rb=%0d lb=%0d scaled=%0b",
                              $realtime, want.lf, want.rf, want.rb, want.lb, want.scaled);
                     $display("%0t:   actual lf=%0d rf=%0d rb=%0d lb=%0d scaled=%0b",
                              $realtime, rsp_wheel_lf, rsp_wheel_rf, rsp_wheel_rb,
                              rsp_wheel_lb, rsp_scaled_down);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Valid is left high after the transaction so that back-to-back ticks need no second
   // assignment in one time step; quiesce lowers it.
   task automatic send_tick(input logic signed [SPEED_W-1:0] x,
                            input logic signed [SPEED_W-1:0] y,
                            input logic signed [SPEED_W-1:0] z,
                            input logic h);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd_x <= x;
      req_cmd_y <= y;
      req_cmd_z <= z;
      req_halt  <= h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_wheel_targets.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_registers(input logic [CFG_W-1:0] enable_word,
                                input logic [CFG_W-1:0] launch,
                                input logic [CFG_W-1:0] normal,
                                input logic [CFG_W-1:0] brake,
                                input logic [CFG_W-1:0] thr,
                                input logic [CFG_W-1:0] lim);
      quiesce();
      write_reg(CSR_RAMP_ENABLE, enable_word);
      write_reg(CSR_LAUNCH_STEP, launch);
      write_reg(CSR_NORMAL_STEP, normal);
      write_reg(CSR_BRAKE_STEP, brake);
      write_reg(CSR_LAUNCH_THR, thr);
      write_reg(CSR_WHEEL_LIMIT, lim);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic signed [SPEED_W-1:0] random_speed();
      int mag_pick;
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0: return SPEED_MIN;
               1: return SPEED_MAX;
               2: return -SPEED_MAX;
               3: return '0;
               default: return SPEED_W'($urandom_range(1) ? 1 : -1);
            endcase
         end
         1: mag_pick = $urandom_range(0, 200);
         2, 3: mag_pick = $urandom_range(0, 4000);
         default: return SPEED_W'($urandom_range(0, 32767));
      endcase
      return SPEED_W'($urandom_range(1) ? mag_pick : -mag_pick);
   endfunction

   function automatic logic [CFG_W-1:0] random_step();
      case ($urandom_range(7))
         0: return '0;
         1: return CFG_MAX;
         2: return CFG_W'(1);
         default: return CFG_W'($urandom_range(1, 1500));
      endcase
   endfunction

   task automatic random_setting();
      logic [CFG_W-1:0] lim;
      logic [CFG_W-1:0] thr;
      case ($urandom_range(15))
         0: lim = '0;
         1: lim = CFG_W'(1);
         2, 3: lim = CFG_MAX;
         default: lim = CFG_W'($urandom_range(500, 16383));
      endcase
      case ($urandom_range(3))
         0: thr = '0;
         1: thr = CFG_MAX;
         default: thr = CFG_W'($urandom_range(0, 8000));
      endcase
      // Upper bits of the enable word are noise; only bit zero counts.
      set_registers({(CFG_W-1)'($urandom), ($urandom_range(3) != 0)},
                    random_step(), random_step(), random_step(), thr, lim);
   endtask

   task automatic test_default_registers();
      send_tick(SPEED_MAX, SPEED_MIN, '0, 1'b0);
      send_tick('0, '0, '0, 1'b0);
      send_tick(-15'sd1, 15'sd1, -15'sd1, 1'b0);
      send_tick(SPEED_MAX, SPEED_MAX, SPEED_MAX, 1'b1);
   endtask

   task automatic test_register_decode();
      quiesce();
      write_reg(CSR_UNMAPPED_LO, CFG_MAX);
      write_reg(CSR_UNMAPPED_HI, CFG_MAX);
      write_reg(CSR_RAMP_ENABLE, CFG_W'(14'h3ffe));
      csr_valid <= 1'b0;
      send_tick(15'sd100, 15'sd200, 15'sd300, 1'b0);
   endtask

   task automatic test_limit_extremes();
      // A zero limit clamps every command to zero, so nothing is scaled.
      set_registers('0, '0, '0, '0, '0, '0);
      send_tick(SPEED_MAX, SPEED_MIN, 15'sd5, 1'b0);
      set_registers('0, '0, '0, '0, '0, CFG_MAX);
      send_tick(SPEED_MAX, SPEED_MAX, SPEED_MAX, 1'b0);
      send_tick(SPEED_MIN, SPEED_MIN, SPEED_MIN, 1'b0);
      send_tick(SPEED_MAX, '0, '0, 1'b0);
      send_tick(15'sd1, 15'sd2, 15'sd3, 1'b0);
      set_registers('0, '0, '0, '0, '0, CFG_W'(1));
      send_tick(15'sd1, '0, '0, 1'b0);
      send_tick('0, '0, '0, 1'b0);
   endtask

   task automatic test_ramp_sequences();
      set_registers(CFG_W'(1), CFG_W'(100), CFG_W'(500), CFG_W'(1000), CFG_W'(2000), CFG_MAX);
      // x launches below the threshold while y accelerates above it.
      send_tick(15'sd1500, -15'sd3000, '0, 1'b0);
      send_tick(15'sd1500, -15'sd3000, '0, 1'b0);
      send_tick(15'sd1500, -15'sd3000, '0, 1'b1);
      send_tick(15'sd1500, -15'sd3000, '0, 1'b0);
      send_tick(15'sd50, -15'sd1500, '0, 1'b0);
      // A zero step freezes the ramp.
      set_registers(CFG_W'(1), CFG_W'(100), '0, CFG_W'(1000), CFG_W'(2000), CFG_MAX);
      send_tick(15'sd5000, -15'sd5000, '0, 1'b0);
      set_registers(CFG_W'(1), CFG_W'(100), CFG_MAX, CFG_MAX, CFG_W'(2000), CFG_MAX);
      send_tick(15'sd9000, -15'sd9000, 15'sd700, 1'b0);
      // The limit drops below the ramp state, which then brakes toward the clamped command.
      set_registers(CFG_W'(1), CFG_W'(100), CFG_MAX, CFG_W'(500), CFG_W'(2000), CFG_W'(1000));
      send_tick(15'sd9000, -15'sd9000, '0, 1'b0);
      send_tick(15'sd9000, -15'sd9000, '0, 1'b0);
      set_registers('0, CFG_W'(100), CFG_MAX, CFG_W'(500), CFG_W'(2000), CFG_W'(1000));
      send_tick(-15'sd300, 15'sd400, '0, 1'b0);
      set_registers(CFG_W'(1), CFG_W'(100), CFG_MAX, CFG_W'(500), CFG_W'(2000), CFG_W'(1000));
      send_tick('0, '0, '0, 1'b0);
   endtask

   // Mostly held commands so that the ramp has time to travel, with some noise mixed in.
   task automatic test_random_traffic(input int items_per_phase);
      int idle_by_phase[4];
      int stall_by_phase[4];
      int phase;
      int sent;
      int next_setting_at;
      int hold;
      int k;
      logic signed [SPEED_W-1:0] tx;
      logic signed [SPEED_W-1:0] ty;
      logic signed [SPEED_W-1:0] tz;
      idle_by_phase  = '{0, 49, 0, 28};
      stall_by_phase = '{0, 0, 49, 28};
      for (phase = 0; phase < 4; phase++) begin
         req_idle_pct  = idle_by_phase[phase];
         rsp_stall_pct = stall_by_phase[phase];
         sent = 0;
         next_setting_at = 0;
         while (sent < items_per_phase) begin
            if (sent >= next_setting_at) begin
               random_setting();
               next_setting_at += SETTING_SPAN;
            end
            tx = random_speed();
            ty = random_speed();
            tz = ($urandom_range(2) == 0) ? '0 : random_speed();
            hold = $urandom_range(1, 12);
            for (k = 0; k < hold; k++) begin
               if ($urandom_range(6) == 0) begin
                  send_tick(random_speed(), random_speed(), random_speed(),
                            1'($urandom_range(1)));
               end else begin
                  send_tick(tx, ty, tz, ($urandom_range(15) == 0));
               end
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_cmd_x = '0;
      req_cmd_y = '0;
      req_cmd_z = '0;
      req_halt  = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_default_registers();
      test_register_decode();
      test_limit_extremes();
      test_ramp_sequences();
      test_random_traffic(RANDOM_PER_PHASE);

      quiesce();
      rsp_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_wheel_targets.size() != 0) failures++;

      $display("Checked %0d of %0d ticks (%0d scaled, %0d halted)",
               ticks_checked, ticks_sent, scaled_seen, halted_ticks);
      $display("across %0d register settings with idle and stall pacing; %0d failures.",
               settings_used, failures);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
